// File: src/c8alu_pkg.sv
package c8alu_pkg;

  typedef enum logic [4:0] {
    FN_ADC = 5'd0,
    FN_SBC = 5'd1,
    FN_AND = 5'd2,
    FN_ORA = 5'd3,
    FN_EOR = 5'd4,
    FN_CMP = 5'd5,
    FN_CPX = 5'd6,
    FN_CPY = 5'd7,
    FN_BIT = 5'd8,
    FN_ASL = 5'd9,
    FN_LSR = 5'd10,
    FN_ROL = 5'd11,
    FN_ROR = 5'd12,
    FN_INC = 5'd13,
    FN_DEC = 5'd14,
    FN_INX = 5'd15,
    FN_INY = 5'd16,
    FN_DEX = 5'd17,
    FN_DEY = 5'd18,
    FN_ANC = 5'd19,
    FN_ALR = 5'd20,
    FN_ARR = 5'd21,
    FN_AXS = 5'd22,
    FN_LOAD = 5'd23,
    FN_SLO = 5'd24,
    FN_RLA = 5'd25,
    FN_SRE = 5'd26,
    FN_RRA = 5'd27,
    FN_DCP = 5'd28,
    FN_ISC = 5'd29,
    FN_LAX = 5'd30
  } alu_func_t;

  // Status byte bit positions.
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  typedef struct packed {
    logic [4:0] func;
    logic [7:0] acc_in;
    logic [7:0] xreg_in;
    logic [7:0] yreg_in;
    logic [7:0] operand;
    logic [7:0] status_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] xreg_out;
    logic [7:0] yreg_out;
    logic [7:0] mem_value;
    logic       mem_write;
    logic [7:0] status_out;
  } out_item_t;

endpackage

// File: src/c8alu_ifs.sv
interface c8alu_in_if import c8alu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c8alu_out_if import c8alu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/c8alu_core.sv
module c8alu_core import c8alu_pkg::*; (
  input  in_item_t  item,
  output out_item_t res
);

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] st;
  } alu_res_t;

  function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[FLAG_Z] = (v == 8'h00);
    q[FLAG_N] = v[7];
    return q;
  endfunction

  function automatic alu_res_t do_adc(logic [7:0] a, logic [7:0] m, logic [7:0] p);
    logic [8:0] sum;
    logic [7:0] ovf;
    alu_res_t   r;
    sum = {1'b0, a} + {1'b0, m} + {8'h00, p[FLAG_C]};
    ovf = (sum[7:0] ^ a) & (sum[7:0] ^ m);
    r.val = sum[7:0];
    r.st = p;
    r.st[FLAG_C] = sum[8];
    r.st[FLAG_V] = ovf[7];
    r.st = set_nz(r.st, sum[7:0]);
    return r;
  endfunction

  // Compare sets C when there is no borrow out of reg - m.
  function automatic logic [7:0] do_cmp(logic [7:0] rg, logic [7:0] m, logic [7:0] p);
    logic [8:0] d;
    logic [7:0] q;
    d = {1'b0, rg} - {1'b0, m};
    q = p;
    q[FLAG_C] = ~d[8];
    return set_nz(q, d[7:0]);
  endfunction

  logic [7:0] a, x, y, m, p, mv, t, ar;
  logic       c, mw;
  alu_res_t   ad;

  always_comb begin
    a  = item.acc_in;
    x  = item.xreg_in;
    y  = item.yreg_in;
    m  = item.operand;
    p  = item.status_in;
    c  = item.status_in[FLAG_C];
    mv = 8'h00;
    mw = 1'b0;
    t  = a & m;
    ar = {c, t[7:1]};
    ad = '0;
    case (item.func)
      FN_ADC: begin
        ad = do_adc(a, m, p);
        a = ad.val;
        p = ad.st;
      end
      FN_SBC: begin
        ad = do_adc(a, ~m, p);
        a = ad.val;
        p = ad.st;
      end
      FN_AND: begin
        a = a & m;
        p = set_nz(p, a);
      end
      FN_ORA: begin
        a = a | m;
        p = set_nz(p, a);
      end
      FN_EOR: begin
        a = a ^ m;
        p = set_nz(p, a);
      end
      FN_CMP: p = do_cmp(a, m, p);
      FN_CPX: p = do_cmp(x, m, p);
      FN_CPY: p = do_cmp(y, m, p);
      FN_BIT: begin
        p[FLAG_Z] = (t == 8'h00);
        p[FLAG_V] = m[6];
        p[FLAG_N] = m[7];
      end
      FN_ASL, FN_SLO: begin
        mv = {m[6:0], 1'b0};
        mw = 1'b1;
        p[FLAG_C] = m[7];
        p = set_nz(p, mv);
        if (item.func == FN_SLO) begin
          a = a | mv;
          p = set_nz(p, a);
        end
      end
      FN_LSR, FN_SRE: begin
        mv = {1'b0, m[7:1]};
        mw = 1'b1;
        p[FLAG_C] = m[0];
        p = set_nz(p, mv);
        if (item.func == FN_SRE) begin
          a = a ^ mv;
          p = set_nz(p, a);
        end
      end
      FN_ROL, FN_RLA: begin
        mv = {m[6:0], c};
        mw = 1'b1;
        p[FLAG_C] = m[7];
        p = set_nz(p, mv);
        if (item.func == FN_RLA) begin
          a = a & mv;
          p = set_nz(p, a);
        end
      end
      FN_ROR, FN_RRA: begin
        mv = {c, m[7:1]};
        mw = 1'b1;
        p[FLAG_C] = m[0];
        p = set_nz(p, mv);
        // The add takes the carry that the rotate shifted out.
        if (item.func == FN_RRA) begin
          ad = do_adc(a, mv, p);
          a = ad.val;
          p = ad.st;
        end
      end
      FN_INC, FN_ISC: begin
        mv = m + 8'd1;
        mw = 1'b1;
        p = set_nz(p, mv);
        if (item.func == FN_ISC) begin
          ad = do_adc(a, ~mv, p);
          a = ad.val;
          p = ad.st;
        end
      end
      FN_DEC, FN_DCP: begin
        mv = m - 8'd1;
        mw = 1'b1;
        p = set_nz(p, mv);
        if (item.func == FN_DCP) begin
          p = do_cmp(a, mv, p);
        end
      end
      FN_INX: begin
        x = x + 8'd1;
        p = set_nz(p, x);
      end
      FN_INY: begin
        y = y + 8'd1;
        p = set_nz(p, y);
      end
      FN_DEX: begin
        x = x - 8'd1;
        p = set_nz(p, x);
      end
      FN_DEY: begin
        y = y - 8'd1;
        p = set_nz(p, y);
      end
      FN_ANC: begin
        a = t;
        p = set_nz(p, a);
        p[FLAG_C] = t[7];
      end
      FN_ALR: begin
        a = {1'b0, t[7:1]};
        p[FLAG_C] = t[0];
        p = set_nz(p, a);
      end
      FN_ARR: begin
        a = ar;
        p = set_nz(p, ar);
        p[FLAG_C] = ar[6];
        p[FLAG_V] = ar[6] ^ ar[5];
      end
      FN_AXS: begin
        p = do_cmp(a & x, m, p);
        x = (a & x) - m;
      end
      FN_LOAD: begin
        a = m;
        p = set_nz(p, m);
      end
      FN_LAX: begin
        a = m;
        x = m;
        p = set_nz(p, m);
      end
      default: begin
        // The spare code leaves everything as it came in.
        mw = 1'b0;
      end
    endcase

    res.acc_out    = a;
    res.xreg_out   = x;
    res.yreg_out   = y;
    res.mem_value  = mv;
    res.mem_write  = mw;
    res.status_out = p;
  end

endmodule

// File: src/cpu8_alu_with_flags.sv
// 8-bit processor ALU with status flags, binary arithmetic only (D is carried
// through untouched). Each transfer on the input channel brings an operation
// code, A, X, Y, the operand byte and the status byte; one result leaves on
// the output channel with the new A, X, Y, the write-back byte with its
// strobe, and the new status. The block takes one item every clock cycle while
// the output is not stalled. Each item is held in the input register, then the
// ALU logic feeds the result register. A stalled output holds the result
// register, and the input register still takes a new item while it is empty.
module cpu8_alu_with_flags import c8alu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  c8alu_in_if.sink           in_ch,
  c8alu_out_if.source        out_ch
);

  in_item_t  s1_r;
  logic      s1_vld_r, s1_vld_nxt;
  out_item_t out_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t alu_res;
  logic      s1_take, s2_take;

  c8alu_core u_core (
    .item (s1_r),
    .res  (alu_res)
  );

  assign s2_take = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign s1_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_vld_r || s2_take;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (s1_take) begin
      s1_vld_nxt = 1'b1;
    end else if (s2_take) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s2_take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_r <= in_ch.data;
    end
    if (s2_take) begin
      out_r <= alu_res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

// File: dv/cpu8_alu_with_flags_checker.sv
`timescale 1ns / 1ps

module cpu8_alu_with_flags_checker import c8alu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  c8alu_in_if   in_mon,
  c8alu_out_if  out_mon,
  output int    fail_count,
  output int    pending
);

  localparam int PRINT_CAP = 40;

  out_item_t alu_results_due[$];
  int        bad_results = 0;
  int        due_count = 0;

  assign fail_count = bad_results;
  assign pending    = due_count;

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
    p[FLAG_Z] = (v == 8'h00);
    p[FLAG_N] = v[7];
    return p;
  endfunction

  function automatic logic [7:0] add_carry(logic [7:0] a, logic [7:0] m,
                                           inout logic [7:0] p);
    logic [8:0] sum;
    logic [7:0] r;
    logic [7:0] ovf;
    sum = {1'b0, a} + {1'b0, m} + {8'h00, p[FLAG_C]};
    r = sum[7:0];
    ovf = (r ^ a) & (r ^ m);
    p[FLAG_C] = sum[8];
    p[FLAG_V] = ovf[7];
    p = with_nz(p, r);
    return r;
  endfunction

  function automatic void compare_to(logic [7:0] r, logic [7:0] m,
                                     inout logic [7:0] p);
    logic [7:0] diff;
    diff = r - m;
    p[FLAG_C] = (r >= m);
    p = with_nz(p, diff);
  endfunction

  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t  res;
    logic [7:0] a, x, y, m, p, mv, t;
    logic       c, mw;
    a  = it.acc_in;
    x  = it.xreg_in;
    y  = it.yreg_in;
    m  = it.operand;
    p  = it.status_in;
    c  = it.status_in[FLAG_C];
    mv = 8'h00;
    mw = 1'b0;
    case (it.func)
      FN_ADC: a = add_carry(a, m, p);
      FN_SBC: a = add_carry(a, ~m, p);
      FN_AND: begin a = a & m; p = with_nz(p, a); end
      FN_ORA: begin a = a | m; p = with_nz(p, a); end
      FN_EOR: begin a = a ^ m; p = with_nz(p, a); end
      FN_CMP: compare_to(a, m, p);
      FN_CPX: compare_to(x, m, p);
      FN_CPY: compare_to(y, m, p);
      FN_BIT: begin
        p[FLAG_Z] = ((a & m) == 8'h00);
        p[FLAG_V] = m[6];
        p[FLAG_N] = m[7];
      end
      FN_ASL, FN_SLO: begin
        mv = {m[6:0], 1'b0};
        mw = 1'b1;
        p[FLAG_C] = m[7];
        p = with_nz(p, mv);
        if (it.func == FN_SLO) begin
          a = a | mv;
          p = with_nz(p, a);
        end
      end
      FN_LSR, FN_SRE: begin
        mv = {1'b0, m[7:1]};
        mw = 1'b1;
        p[FLAG_C] = m[0];
        p = with_nz(p, mv);
        if (it.func == FN_SRE) begin
          a = a ^ mv;
          p = with_nz(p, a);
        end
      end
      FN_ROL, FN_RLA: begin
        mv = {m[6:0], c};
        mw = 1'b1;
        p[FLAG_C] = m[7];
        p = with_nz(p, mv);
        if (it.func == FN_RLA) begin
          a = a & mv;
          p = with_nz(p, a);
        end
      end
      FN_ROR, FN_RRA: begin
        mv = {c, m[7:1]};
        mw = 1'b1;
        p[FLAG_C] = m[0];
        p = with_nz(p, mv);
        // The add picks up the carry that the rotate just produced.
        if (it.func == FN_RRA) a = add_carry(a, mv, p);
      end
      FN_INC, FN_ISC: begin
        mv = m + 8'h01;
        mw = 1'b1;
        p = with_nz(p, mv);
        if (it.func == FN_ISC) a = add_carry(a, ~mv, p);
      end
      FN_DEC, FN_DCP: begin
        mv = m - 8'h01;
        mw = 1'b1;
        p = with_nz(p, mv);
        if (it.func == FN_DCP) compare_to(a, mv, p);
      end
      FN_INX: begin x = x + 8'h01; p = with_nz(p, x); end
      FN_INY: begin y = y + 8'h01; p = with_nz(p, y); end
      FN_DEX: begin x = x - 8'h01; p = with_nz(p, x); end
      FN_DEY: begin y = y - 8'h01; p = with_nz(p, y); end
      FN_ANC: begin
        a = a & m;
        p = with_nz(p, a);
        p[FLAG_C] = a[7];
      end
      FN_ALR: begin
        t = a & m;
        a = {1'b0, t[7:1]};
        p[FLAG_C] = t[0];
        p = with_nz(p, a);
      end
      FN_ARR: begin
        t = a & m;
        a = {c, t[7:1]};
        p = with_nz(p, a);
        p[FLAG_C] = a[6];
        p[FLAG_V] = a[6] ^ a[5];
      end
      FN_AXS: begin
        t = a & x;
        compare_to(t, m, p);
        x = t - m;
      end
      FN_LOAD: begin a = m; p = with_nz(p, a); end
      FN_LAX: begin
        a = m;
        x = m;
        p = with_nz(p, m);
      end
      default: ;
    endcase
    res.acc_out    = a;
    res.xreg_out   = x;
    res.yreg_out   = y;
    res.mem_value  = mv;
    res.mem_write  = mw;
    res.status_out = p;
    return res;
  endfunction

  function automatic int field_bad(string name, logic [7:0] want, logic [7:0] got,
                                   int shown);
    if (want === got) return 0;
    if (shown < PRINT_CAP)
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    int        errs_now;
    out_item_t want;
    out_item_t got;
    errs_now = 0;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        alu_results_due = {alu_results_due, alu_predict(in_mon.data)};
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (alu_results_due.size() == 0) begin
          if (bad_results < PRINT_CAP)
            $display("%0t: result transfer with none outstanding, expected nothing, actual %h",
                     $realtime, got);
          errs_now = 1;
        end else begin
          want = alu_results_due.pop_front();
          errs_now += field_bad("acc_out", want.acc_out, got.acc_out, bad_results);
          errs_now += field_bad("xreg_out", want.xreg_out, got.xreg_out, bad_results);
          errs_now += field_bad("yreg_out", want.yreg_out, got.yreg_out, bad_results);
          errs_now += field_bad("mem_value", want.mem_value, got.mem_value, bad_results);
          errs_now += field_bad("mem_write", {7'd0, want.mem_write}, {7'd0, got.mem_write},
                                bad_results);
          errs_now += field_bad("status_out", want.status_out, got.status_out, bad_results);
        end
      end
    end
    bad_results <= bad_results + errs_now;
    due_count   <= alu_results_due.size();
  end

endmodule

// File: dv/cpu8_alu_with_flags_test.sv
`timescale 1ns / 1ps

module cpu8_alu_with_flags_test import c8alu_pkg::*; ();

  localparam logic [4:0] FN_UNUSED   = 5'd31;
  localparam int         RANDOM_OPS  = 450;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         TAIL_CYCLES = 10;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB} rx_mode_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  c8alu_in_if  in_ch ();
  c8alu_out_if out_ch ();

  cpu8_alu_with_flags dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cpu8_alu_with_flags_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: each stretch picks a stall style and holds it for a while.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 90);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= (rx_phase + 1) % 7;
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= ($urandom_range(0, 9) < 6);
      default:   out_ch.ready <= (rx_phase >= 3);
    endcase
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_op(in_item_t op);
    in_ch.valid <= 1'b1;
    in_ch.data  <= op;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The outstanding count is registered in the checker, hence the first step.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] corner [4];
    in_item_t   op;
    int         sent;
    int         burst;
    int         gap;
    bit         paused;

    corner = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every operation code, the unused one included, on corner values.
    for (int f = 0; f <= FN_UNUSED; f++) begin
      op.func      = f[4:0];
      op.acc_in    = corner[f % 4];
      op.xreg_in   = corner[(f + 1) % 4];
      op.yreg_in   = corner[(f + 2) % 4];
      op.operand   = corner[(f + 3) % 4];
      op.status_in = f[0] ? 8'hFF : 8'h00;
      push_op(op);
    end
    // Signed overflow on add and subtract, and a compare that comes out equal.
    op = '{FN_ADC, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00};
    push_op(op);
    op = '{FN_SBC, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01};
    push_op(op);
    op = '{FN_CMP, 8'h42, 8'h00, 8'h00, 8'h42, 8'h00};
    push_op(op);
    in_ch.valid <= 1'b0;
    wait_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_OPS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_OPS; k++) begin
        op.func      = 5'($urandom_range(0, 31));
        op.acc_in    = pick_byte();
        op.xreg_in   = pick_byte();
        op.yreg_in   = pick_byte();
        op.operand   = pick_byte();
        op.status_in = pick_byte();
        push_op(op);
        sent++;
      end
      if (!paused && sent >= RANDOM_OPS / 2) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        wait_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
src/c8alu_pkg.sv
src/c8alu_ifs.sv
src/c8alu_core.sv
src/cpu8_alu_with_flags.sv
dv/cpu8_alu_with_flags_checker.sv
dv/cpu8_alu_with_flags_test.sv
